FILE: hw/rtl/ged_pkg.sv
package ged_pkg;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned SIDE    = 2 ** IDX_W;
  localparam int unsigned ADDR_W  = 2 * IDX_W;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ACC_W   = 12;
  localparam int unsigned SUM_W   = 2 * PIX_W + 1;
  localparam int unsigned RAD_W   = SUM_W + 1;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned TAP_W   = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIDE - 1);

  localparam int unsigned PRE_RECIP = 683;
  localparam int unsigned PRE_SHIFT = 11;
  localparam int unsigned SOB_SHIFT = 2;

  localparam logic [1:0] MODE_THREE   = 2'd0;
  localparam logic [1:0] MODE_ROBERTS = 2'd1;
  localparam logic [1:0] MODE_PREWITT = 2'd2;
  localparam logic [1:0] MODE_SOBEL   = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic CFG_MODE      = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [1:0]       MODE_RESET      = MODE_THREE;
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(40);

  typedef struct packed {
    logic signed [1:0] dr;
    logic signed [1:0] dc;
    logic signed [2:0] wr;
    logic signed [2:0] wc;
    logic              last;
  } tap_t;

  function automatic tap_t mk_tap(input logic signed [1:0] dr, input logic signed [1:0] dc,
                                  input logic signed [2:0] wr, input logic signed [2:0] wc,
                                  input logic last);
    tap_t t;
    t.dr   = dr;
    t.dc   = dc;
    t.wr   = wr;
    t.wc   = wc;
    t.last = last;
    return t;
  endfunction

  function automatic tap_t tap_lookup(input logic [1:0] mode, input logic [TAP_W-1:0] k);
    tap_t              t;
    logic signed [2:0] w;
    w = (mode == MODE_SOBEL) ? 3'sd2 : 3'sd1;
    t = mk_tap(2'sd0, 2'sd0, 3'sd0, 3'sd0, 1'b1);
    case (mode)
      MODE_THREE: begin
        case (k)
          3'd0:    t = mk_tap( 2'sd0,  2'sd0,  3'sd1,  3'sd1, 1'b0);
          3'd1:    t = mk_tap( 2'sd0, -2'sd1, -3'sd1,  3'sd0, 1'b0);
          default: t = mk_tap( 2'sd1,  2'sd0,  3'sd0, -3'sd1, 1'b1);
        endcase
      end
      MODE_ROBERTS: begin
        case (k)
          3'd0:    t = mk_tap( 2'sd0,  2'sd0,  3'sd1,  3'sd0, 1'b0);
          3'd1:    t = mk_tap( 2'sd1,  2'sd1, -3'sd1,  3'sd0, 1'b0);
          3'd2:    t = mk_tap( 2'sd0,  2'sd1,  3'sd0,  3'sd1, 1'b0);
          default: t = mk_tap( 2'sd1,  2'sd0,  3'sd0, -3'sd1, 1'b1);
        endcase
      end
      default: begin
        case (k)
          3'd0:    t = mk_tap(-2'sd1, -2'sd1, -3'sd1,  3'sd1, 1'b0);
          3'd1:    t = mk_tap(-2'sd1,  2'sd0,  3'sd0,  w,     1'b0);
          3'd2:    t = mk_tap(-2'sd1,  2'sd1,  3'sd1,  3'sd1, 1'b0);
          3'd3:    t = mk_tap( 2'sd0, -2'sd1, -w,      3'sd0, 1'b0);
          3'd4:    t = mk_tap( 2'sd0,  2'sd1,  w,      3'sd0, 1'b0);
          3'd5:    t = mk_tap( 2'sd1, -2'sd1, -3'sd1, -3'sd1, 1'b0);
          3'd6:    t = mk_tap( 2'sd1,  2'sd0,  3'sd0, -w,     1'b0);
          default: t = mk_tap( 2'sd1,  2'sd1,  3'sd1, -3'sd1, 1'b1);
        endcase
      end
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/ged_isqrt.sv
module ged_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ged_pkg::RAD_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [ged_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned REM_W = ged_pkg::ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ged_pkg::ROOT_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [ged_pkg::RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [ged_pkg::ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]           rem_t;
  logic [REM_W-1:0]           trial;

  assign rem_t = {rem_q[REM_W-3:0], rad_q[ged_pkg::RAD_W-1 -: 2]};
  assign trial = REM_W'({root_q, 2'b01});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[ged_pkg::RAD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_d  = rem_t - trial;
        root_d = {root_q[ged_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_t;
        root_d = {root_q[ged_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ged_pkg::ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: hw/rtl/gradient_edge_detector.sv
// Gradient edge detector over a 256 x 256 frame of 8-bit pixels.
// Input stream: tuser carries the operation (0 write pixel, 1 evaluate pixel);
// tdata carries row, column and pixel value. A write stores the pixel into the
// frame memory (one write port, one read port). An evaluate reads the operator's
// taps one per cycle from that memory (3 for three-point, 4 for Roberts, 8 for
// Prewitt and Sobel), scales, squares both gradients on one shared multiplier
// and runs a 9-step iterative square root. The result beat (magnitude in tdata,
// edge flag in tuser) is valid once the read, scale, square and root steps have
// run in that order. Input tready is low while an evaluate is in flight, so a
// new evaluate is taken only after the previous result enters the output register.
// The result sits in an output register: the block keeps taking beats while
// it waits, and a second evaluate holds at the end until the register frees.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i (0 mode,
// 1 threshold); write only while the block is idle.
// Reset clears the sequencer, the output valid and loads mode 0 and threshold
// 40; the frame memory is not cleared, so read only pixels already written.
module gradient_edge_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // row_index[7:0], col_index[15:8], pixel_value[23:16]
  input  logic        s_axis_tuser_i,  // operation[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // magnitude[7:0]
  output logic        m_axis_tuser_o,  // edge_found[0]
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned IDX_W  = ged_pkg::IDX_W;
  localparam int unsigned PIX_W  = ged_pkg::PIX_W;
  localparam int unsigned ACC_W  = ged_pkg::ACC_W;
  localparam int unsigned SUM_W  = ged_pkg::SUM_W;
  localparam int unsigned TAP_W  = ged_pkg::TAP_W;
  localparam int unsigned DIV_W  = (ACC_W - 1) + 10;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_SQ_R  = 4'd4;
  localparam logic [3:0] S_SQ_C  = 4'd5;
  localparam logic [3:0] S_START = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  function automatic logic signed [ACC_W-1:0] weigh(input logic [PIX_W-1:0] p,
                                                    input logic signed [2:0] w);
    logic signed [ACC_W-1:0] pe;
    logic signed [ACC_W-1:0] m;
    pe = $signed(ACC_W'(p));
    m  = (w == 3'sd2 || w == -3'sd2) ? (pe <<< 1) : pe;
    if (w == 3'sd0) begin
      return '0;
    end else if (w < 0) begin
      return -m;
    end
    return m;
  endfunction

  function automatic logic [PIX_W-1:0] scale(input logic signed [ACC_W-1:0] a,
                                             input logic [1:0] mode);
    logic [ACC_W-2:0] mag;
    logic [DIV_W-1:0] prod;
    mag  = a[ACC_W-1] ? (ACC_W-1)'(-a) : a[ACC_W-2:0];
    prod = DIV_W'(mag) * DIV_W'(ged_pkg::PRE_RECIP);
    case (mode)
      ged_pkg::MODE_PREWITT: return prod[ged_pkg::PRE_SHIFT +: PIX_W];
      ged_pkg::MODE_SOBEL:   return mag[ged_pkg::SOB_SHIFT +: PIX_W];
      default:               return mag[PIX_W-1:0];
    endcase
  endfunction

  logic [PIX_W-1:0] frame_mem [ged_pkg::SIDE * ged_pkg::SIDE];

  logic [3:0]                 state_q, state_d;
  logic [1:0]                 mode_q;
  logic [PIX_W-1:0]           threshold_q;
  logic [TAP_W-1:0]           k_q, k_d;
  logic                       acc_en_q, acc_en_d;
  logic                       out_valid_q, out_valid_d;
  logic [IDX_W-1:0]           row_q, row_d;
  logic [IDX_W-1:0]           col_q, col_d;
  logic signed [2:0]          wr_q, wr_d;
  logic signed [2:0]          wc_q, wc_d;
  logic signed [ACC_W-1:0]    gr_q, gr_d;
  logic signed [ACC_W-1:0]    gc_q, gc_d;
  logic [PIX_W-1:0]           agr_q, agr_d;
  logic [PIX_W-1:0]           agc_q, agc_d;
  logic [SUM_W-1:0]           sum_q, sum_d;
  logic [PIX_W-1:0]           mag_q, mag_d;
  logic                       edge_q, edge_d;
  logic [PIX_W-1:0]           rd_data_q;

  ged_pkg::tap_t              tap;
  logic [IDX_W-1:0]           row_a, col_a;
  logic [ged_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic                       in_beat, wr_en;
  logic                       fit_r, fit_c;
  logic [PIX_W-1:0]           sq_a;
  logic [2*PIX_W-1:0]         sq_p;
  logic                       root_start, root_done;
  logic [ged_pkg::ROOT_W-1:0] root;
  logic [PIX_W-1:0]           root_sat;
  logic                       load_out;

  ged_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i ({1'b0, sum_q}),
    .done_o     (root_done),
    .root_o     (root)
  );

  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en   = in_beat && (s_axis_tuser_i == ged_pkg::OP_WRITE);
  assign wr_addr = {s_axis_tdata_i[IDX_W-1:0], s_axis_tdata_i[2*IDX_W-1:IDX_W]};

  assign tap     = ged_pkg::tap_lookup(mode_q, k_q);
  assign row_a   = row_q + {{(IDX_W-2){tap.dr[1]}}, tap.dr};
  assign col_a   = col_q + {{(IDX_W-2){tap.dc[1]}}, tap.dc};
  assign rd_addr = {row_a, col_a};

  assign sq_a       = (state_q == S_SQ_R) ? agr_q : agc_q;
  assign sq_p       = sq_a * sq_a;
  assign root_start = (state_q == S_START);
  assign root_sat   = (|root[ged_pkg::ROOT_W-1:PIX_W]) ? {PIX_W{1'b1}} : root[PIX_W-1:0];
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    case (mode_q)
      ged_pkg::MODE_THREE: begin
        fit_r = (col_q != '0);
        fit_c = (row_q != ged_pkg::LAST_IDX);
      end
      ged_pkg::MODE_ROBERTS: begin
        fit_r = (row_q != ged_pkg::LAST_IDX) && (col_q != ged_pkg::LAST_IDX);
        fit_c = fit_r;
      end
      default: begin
        fit_r = (row_q != '0) && (row_q != ged_pkg::LAST_IDX) &&
                (col_q != '0) && (col_q != ged_pkg::LAST_IDX);
        fit_c = fit_r;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    acc_en_d    = 1'b0;
    row_d       = row_q;
    col_d       = col_q;
    wr_d        = tap.wr;
    wc_d        = tap.wc;
    gr_d        = gr_q;
    gc_d        = gc_q;
    agr_d       = agr_q;
    agc_d       = agc_q;
    sum_d       = sum_q;
    mag_d       = mag_q;
    edge_d      = edge_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (acc_en_q) begin
      gr_d = gr_q + weigh(rd_data_q, wr_q);
      gc_d = gc_q + weigh(rd_data_q, wc_q);
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat && s_axis_tuser_i == ged_pkg::OP_EVAL) begin
          row_d   = s_axis_tdata_i[IDX_W-1:0];
          col_d   = s_axis_tdata_i[2*IDX_W-1:IDX_W];
          k_d     = '0;
          gr_d    = '0;
          gc_d    = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        acc_en_d = 1'b1;
        k_d      = k_q + TAP_W'(1);
        if (tap.last) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_SCALE;
      end
      S_SCALE: begin
        agr_d   = fit_r ? scale(gr_q, mode_q) : '0;
        agc_d   = fit_c ? scale(gc_q, mode_q) : '0;
        state_d = S_SQ_R;
      end
      S_SQ_R: begin
        sum_d   = SUM_W'(sq_p);
        state_d = S_SQ_C;
      end
      S_SQ_C: begin
        sum_d   = sum_q + SUM_W'(sq_p);
        state_d = S_START;
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (root_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          mag_d       = root_sat;
          edge_d      = (root_sat >= threshold_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      acc_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ged_pkg::MODE_RESET;
      threshold_q <= ged_pkg::THRESHOLD_RESET;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      acc_en_q    <= acc_en_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ged_pkg::CFG_MODE:      mode_q      <= cfg_data_i[1:0];
          ged_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    wr_q   <= wr_d;
    wc_q   <= wc_d;
    gr_q   <= gr_d;
    gc_q   <= gc_d;
    agr_q  <= agr_d;
    agc_q  <= agc_d;
    sum_q  <= sum_d;
    mag_q  <= mag_d;
    edge_q <= edge_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= s_axis_tdata_i[2*IDX_W +: PIX_W];
    end
    rd_data_q <= frame_mem[rd_addr];
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mag_q;
  assign m_axis_tuser_o  = edge_q;

endmodule
